// ===== design/bqss_pkg.sv =====
`timescale 1ns / 1ps

package bqss_pkg;

  // Default sizes of the cascade.
  localparam int MAX_SECTIONS_DEF = 4;
  localparam int STATE_WIDTH_DEF  = 48;

  // Coefficient and gain words are signed Q4.28.
  localparam int COEF_W = 32;
  localparam int FRAC_C = 28;

  // The state operand of a multiply is split at this bit: the low part is
  // taken unsigned, the high part signed.
  localparam int LO_W = 32;

  typedef logic signed [COEF_W-1:0] coef_t;

  // Item commands.
  localparam logic CMD_FILTER = 1'b0;
  localparam logic CMD_COEF   = 1'b1;

  // Coefficient slots within a section.
  localparam logic [1:0] COEF_B1 = 2'd0;
  localparam logic [1:0] COEF_B2 = 2'd1;
  localparam logic [1:0] COEF_A1 = 2'd2;
  localparam logic [1:0] COEF_A2 = 2'd3;

  // Delay slots within a section.
  localparam logic DLY_W0 = 1'b0;
  localparam logic DLY_W1 = 1'b1;

  // Configuration registers.
  localparam int         CFG_IDX_W         = 2;
  localparam logic [1:0] CFG_OUTPUT_GAIN   = 2'd0;
  localparam logic [1:0] CFG_SECTIONS_USED = 2'd1;
  localparam logic [31:0] GAIN_RESET       = 32'h1000_0000;

endpackage

// ===== design/bqss_mul.sv =====
`timescale 1ns / 1ps

// Signed state word times signed Q4.28 coefficient, split into two
// registered partial products. The full product is hi_prod * 2^32 + lo_prod.
module bqss_mul #(
  parameter int STATE_WIDTH = bqss_pkg::STATE_WIDTH_DEF
) (
  input  logic                                        clk,
  input  logic signed [STATE_WIDTH-1:0]               s_op,
  input  bqss_pkg::coef_t                             c_op,
  output logic signed [bqss_pkg::LO_W+bqss_pkg::COEF_W:0] lo_prod,
  output logic signed [STATE_WIDTH-1:0]               hi_prod
);

  logic signed [bqss_pkg::LO_W:0]                   lo_a;
  logic signed [STATE_WIDTH-bqss_pkg::LO_W-1:0]     hi_a;
  logic signed [bqss_pkg::LO_W+bqss_pkg::COEF_W:0]  lo_r;
  logic signed [STATE_WIDTH-1:0]                    hi_r;

  assign lo_a = {1'b0, s_op[bqss_pkg::LO_W-1:0]};
  assign hi_a = s_op[STATE_WIDTH-1:bqss_pkg::LO_W];

  always_ff @(posedge clk) begin
    lo_r <= lo_a * c_op;
    hi_r <= hi_a * c_op;
  end

  assign lo_prod = lo_r;
  assign hi_prod = hi_r;

endmodule

// ===== design/biquad_cascade_sum_squares.sv =====
// Biquad cascade with output gain and block sum of squares.
// Input channel (in_valid / in_stall): a transfer with in_command at filter
// carries one signed 24-bit sample through the sections in use; a transfer
// with in_command at coefficient writes one coefficient and gives no result.
// Result channel (out_valid / out_stall): one transfer per filtered sample with
// the gained output, the block sum (nonzero only when out_last_out is set)
// and a flag that any value clipped on that sample.
// Configuration channel (cfg_valid / cfg_ready): register 0 is the output
// gain, register 1 the number of sections used; write only while idle.
// A filter item keeps the input channel stalled until its result is loaded
// into the output register. The sequencer steps through RD1..Y3 once for
// each section in use (1 to MAX_SECTIONS), sharing the single split
// multiplier and the one-port coefficient and delay memories for four
// products and two rounding steps per section, then through G0..G2, SQ, SUM.
// A coefficient write is done in the idle state and stalls nothing.
// Reset sets the gain to 1.0, one section, an empty sum, and marks every
// coefficient and delay entry as zero through valid bits; there is no
// clearing pass. While out_stall holds, the result stays in the output
// register and the block still takes the next item; a second finished sample
// waits in the last stage until the first result transfer completes.
`timescale 1ns / 1ps

module biquad_cascade_sum_squares #(
  parameter int MAX_SECTIONS = bqss_pkg::MAX_SECTIONS_DEF,
  parameter int STATE_WIDTH  = bqss_pkg::STATE_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_command,
  input  logic signed [23:0]                   in_sample,
  input  logic                                 in_last_in,
  input  logic [1:0]                           in_section_index,
  input  logic [1:0]                           in_coef_select,
  input  logic signed [31:0]                   in_coef_value,
  // Result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [31:0]                   out_filtered_sample,
  output logic [63:0]                          out_block_sum_squares,
  output logic                                 out_last_out,
  output logic                                 out_saturated,
  // Configuration channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bqss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_data
);

  localparam int SW     = STATE_WIDTH;
  localparam int ACC_W  = STATE_WIDTH + 34;
  localparam int SEC_W  = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CA_W   = SEC_W + 2;
  localparam int DA_W   = SEC_W + 1;
  localparam int N_COEF = 4 * MAX_SECTIONS;
  localparam int N_DLY  = 2 * MAX_SECTIONS;
  localparam int PL_W   = bqss_pkg::LO_W + bqss_pkg::COEF_W + 1;

  // Sequencer states. RD1..Y3 repeat once per section in use.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RD1  = 4'd1;
  localparam logic [3:0] ST_RD2  = 4'd2;
  localparam logic [3:0] ST_RD3  = 4'd3;
  localparam logic [3:0] ST_WSAT = 4'd4;
  localparam logic [3:0] ST_Y0   = 4'd5;
  localparam logic [3:0] ST_Y1   = 4'd6;
  localparam logic [3:0] ST_Y2   = 4'd7;
  localparam logic [3:0] ST_Y3   = 4'd8;
  localparam logic [3:0] ST_G0   = 4'd9;
  localparam logic [3:0] ST_G1   = 4'd10;
  localparam logic [3:0] ST_G2   = 4'd11;
  localparam logic [3:0] ST_SQ   = 4'd12;
  localparam logic [3:0] ST_SUM  = 4'd13;

  logic [3:0]              state_r, state_nxt;
  logic [SEC_W-1:0]        sec_r;
  logic [SEC_W-1:0]        last_sec;
  logic [SEC_W-1:0]        rd_sec;

  // Configuration registers.
  bqss_pkg::coef_t         gain_r;
  logic [2:0]              sections_used_r;

  // Memories and their valid bits; an entry never written reads as zero.
  bqss_pkg::coef_t         coef_mem [N_COEF];
  logic [N_COEF-1:0]       coef_vld_r;
  bqss_pkg::coef_t         coef_q_r;
  logic                    coef_qv_r;
  bqss_pkg::coef_t         coef_rd;
  logic [CA_W-1:0]         coef_ra;
  logic [CA_W-1:0]         coef_wa;
  logic                    coef_we;

  logic signed [SW-1:0]    dly_mem [N_DLY];
  logic [N_DLY-1:0]        dly_vld_r;
  logic signed [SW-1:0]    dly_q_r;
  logic                    dly_qv_r;
  logic signed [SW-1:0]    dly_rd;
  logic [DA_W-1:0]         dly_ra;
  logic [DA_W-1:0]         dly_wa;
  logic signed [SW-1:0]    dly_wd;
  logic                    dly_we;

  // Datapath registers.
  logic signed [SW-1:0]    y_r;
  logic signed [SW-1:0]    w0_r;
  logic signed [SW-1:0]    w1_r;
  logic signed [SW-1:0]    wn_r;
  bqss_pkg::coef_t         b1_r;
  bqss_pkg::coef_t         b2_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [31:0]      res_r;
  logic [63:0]             sq_r;
  logic [63:0]             sacc_r;
  logic                    last_r;
  logic                    clip_r;

  // Multiplier operands and partial products.
  logic signed [SW-1:0]    mul_s;
  bqss_pkg::coef_t         mul_c;
  logic signed [PL_W-1:0]  lo_prod;
  logic signed [SW-1:0]    hi_prod;
  logic signed [ACC_W-1:0] prod_hi_ext;
  logic signed [ACC_W-1:0] prod_lo_ext;

  // Rounding and saturation.
  logic signed [ACC_W-1:0] rnd_w;
  logic                    w_ovf;
  logic signed [SW-1:0]    w_sat;
  logic signed [ACC_W-1:0] rnd_g;
  logic                    g_ovf;
  logic signed [31:0]      g_sat;

  logic [31:0]             mag;
  logic [64:0]             sum_wide;
  logic [63:0]             sum_sat;

  logic                    in_xfer;
  logic                    out_free;
  logic                    load_out;

  logic signed [31:0]      out_sample_r;
  logic [63:0]             out_sum_r;
  logic                    out_last_r;
  logic                    out_sat_r;
  logic                    out_valid_r;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;
  assign load_out  = (state_r == ST_SUM) && out_free;

  // Section count in use, clamped to 1..MAX_SECTIONS, as the last index.
  always_comb begin
    if (sections_used_r == 3'd0) begin
      last_sec = '0;
    end else if (32'(sections_used_r) > MAX_SECTIONS) begin
      last_sec = SEC_W'(MAX_SECTIONS - 1);
    end else begin
      last_sec = SEC_W'(sections_used_r - 3'd1);
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r          <= bqss_pkg::GAIN_RESET;
      sections_used_r <= 3'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bqss_pkg::CFG_OUTPUT_GAIN:   gain_r <= cfg_data;
        bqss_pkg::CFG_SECTIONS_USED: sections_used_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Read addresses are set in the state before the step that uses the data.
  // The last step of a section already fetches a1 and w0 of the next one.
  always_comb begin
    case (state_r)
      ST_IDLE: rd_sec = '0;
      ST_Y3:   rd_sec = (sec_r == last_sec) ? sec_r : sec_r + SEC_W'(1);
      default: rd_sec = sec_r;
    endcase
    case (state_r)
      ST_RD1:  coef_ra = {rd_sec, bqss_pkg::COEF_A2};
      ST_RD2:  coef_ra = {rd_sec, bqss_pkg::COEF_B1};
      ST_RD3:  coef_ra = {rd_sec, bqss_pkg::COEF_B2};
      default: coef_ra = {rd_sec, bqss_pkg::COEF_A1};
    endcase
    case (state_r)
      ST_RD1:  dly_ra = {rd_sec, bqss_pkg::DLY_W1};
      default: dly_ra = {rd_sec, bqss_pkg::DLY_W0};
    endcase
  end

  // Coefficient memory: written by coefficient items, read by the sequencer.
  // Writes to a section beyond the cascade are dropped.
  assign coef_we = in_xfer && (in_command == bqss_pkg::CMD_COEF) &&
                   (32'(in_section_index) < MAX_SECTIONS);
  assign coef_wa = {SEC_W'(in_section_index), in_coef_select};

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_wa] <= in_coef_value;
    end
    coef_q_r <= coef_mem[coef_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_vld_r <= '0;
      coef_qv_r  <= 1'b0;
    end else begin
      if (coef_we) begin
        coef_vld_r[coef_wa] <= 1'b1;
      end
      coef_qv_r <= coef_vld_r[coef_ra];
    end
  end

  assign coef_rd = coef_qv_r ? coef_q_r : '0;

  // Delay memory: w1 takes the old w0 once the new w is known, then w0 takes
  // the new w. Both writes land after this section's reads.
  assign dly_we = (state_r == ST_WSAT) || (state_r == ST_Y0);
  assign dly_wa = (state_r == ST_WSAT) ? {sec_r, bqss_pkg::DLY_W1}
                                       : {sec_r, bqss_pkg::DLY_W0};
  assign dly_wd = (state_r == ST_WSAT) ? w0_r : wn_r;

  always_ff @(posedge clk) begin
    if (dly_we) begin
      dly_mem[dly_wa] <= dly_wd;
    end
    dly_q_r <= dly_mem[dly_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dly_vld_r <= '0;
      dly_qv_r  <= 1'b0;
    end else begin
      if (dly_we) begin
        dly_vld_r[dly_wa] <= 1'b1;
      end
      dly_qv_r <= dly_vld_r[dly_ra];
    end
  end

  assign dly_rd = dly_qv_r ? dly_q_r : '0;

  // The multiplier runs every cycle; the sequencer picks its operands and
  // folds the registered products into the accumulator in the next step.
  always_comb begin
    case (state_r)
      ST_Y0: begin
        mul_s = w0_r;
        mul_c = b1_r;
      end
      ST_Y1: begin
        mul_s = w1_r;
        mul_c = b2_r;
      end
      ST_G0: begin
        mul_s = y_r;
        mul_c = gain_r;
      end
      default: begin
        mul_s = dly_rd;
        mul_c = coef_rd;
      end
    endcase
  end

  bqss_mul #(
    .STATE_WIDTH (STATE_WIDTH)
  ) u_mul (
    .clk     (clk),
    .s_op    (mul_s),
    .c_op    (mul_c),
    .lo_prod (lo_prod),
    .hi_prod (hi_prod)
  );

  assign prod_hi_ext = ACC_W'(hi_prod) <<< bqss_pkg::LO_W;
  assign prod_lo_ext = ACC_W'(lo_prod);

  // Round half up by 28 bits and saturate to the state width.
  assign rnd_w = (acc_r + (ACC_W'(1) <<< (bqss_pkg::FRAC_C - 1))) >>> bqss_pkg::FRAC_C;
  assign w_ovf = !((&rnd_w[ACC_W-1:SW-1]) || !(|rnd_w[ACC_W-1:SW-1]));
  assign w_sat = !w_ovf ? rnd_w[SW-1:0] :
                 rnd_w[ACC_W-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};

  // The gained output drops 16 state fraction bits and 28 gain fraction bits.
  assign rnd_g = (acc_r + (ACC_W'(1) <<< 43)) >>> 44;
  assign g_ovf = !((&rnd_g[ACC_W-1:31]) || !(|rnd_g[ACC_W-1:31]));
  assign g_sat = !g_ovf ? rnd_g[31:0] :
                 rnd_g[ACC_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;

  assign mag      = res_r[31] ? (32'd0 - res_r) : res_r;
  assign sum_wide = {1'b0, sacc_r} + {1'b0, sq_r};
  assign sum_sat  = sum_wide[64] ? {64{1'b1}} : sum_wide[63:0];

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_command == bqss_pkg::CMD_FILTER)) begin
          state_nxt = ST_RD1;
        end
      end
      ST_RD1:  state_nxt = ST_RD2;
      ST_RD2:  state_nxt = ST_RD3;
      ST_RD3:  state_nxt = ST_WSAT;
      ST_WSAT: state_nxt = ST_Y0;
      ST_Y0:   state_nxt = ST_Y1;
      ST_Y1:   state_nxt = ST_Y2;
      ST_Y2:   state_nxt = ST_Y3;
      ST_Y3:   state_nxt = (sec_r == last_sec) ? ST_G0 : ST_RD1;
      ST_G0:   state_nxt = ST_G1;
      ST_G1:   state_nxt = ST_G2;
      ST_G2:   state_nxt = ST_SQ;
      ST_SQ:   state_nxt = ST_SUM;
      ST_SUM: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sec_r   <= '0;
      sacc_r  <= '0;
      clip_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            sec_r  <= '0;
            clip_r <= 1'b0;
          end
        end
        ST_WSAT: clip_r <= clip_r | w_ovf;
        ST_Y3: begin
          clip_r <= clip_r | w_ovf;
          if (sec_r != last_sec) begin
            sec_r <= sec_r + SEC_W'(1);
          end
        end
        ST_G2: clip_r <= clip_r | g_ovf;
        ST_SUM: begin
          if (out_free) begin
            sacc_r <= last_r ? 64'd0 : sum_sat;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          y_r    <= SW'(in_sample) <<< 16;
          last_r <= in_last_in;
        end
      end
      ST_RD1: begin
        w0_r  <= dly_rd;
        acc_r <= ACC_W'(y_r) <<< bqss_pkg::FRAC_C;
      end
      ST_RD2: begin
        w1_r  <= dly_rd;
        acc_r <= acc_r + prod_hi_ext + prod_lo_ext;
      end
      ST_RD3: begin
        b1_r  <= coef_rd;
        acc_r <= acc_r + prod_hi_ext + prod_lo_ext;
      end
      ST_WSAT: begin
        b2_r <= coef_rd;
        wn_r <= w_sat;
      end
      ST_Y0: acc_r <= ACC_W'(wn_r) <<< bqss_pkg::FRAC_C;
      ST_Y1: acc_r <= acc_r + prod_hi_ext + prod_lo_ext;
      ST_Y2: acc_r <= acc_r + prod_hi_ext + prod_lo_ext;
      ST_Y3: y_r   <= w_sat;
      ST_G1: acc_r <= prod_hi_ext + prod_lo_ext;
      ST_G2: res_r <= g_sat;
      ST_SQ: sq_r  <= mag * mag;
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_sample_r <= res_r;
      out_sum_r    <= last_r ? sum_sat : 64'd0;
      out_last_r   <= last_r;
      out_sat_r    <= clip_r | sum_wide[64];
    end
  end

  assign out_valid             = out_valid_r;
  assign out_filtered_sample   = out_sample_r;
  assign out_block_sum_squares = out_sum_r;
  assign out_last_out          = out_last_r;
  assign out_saturated         = out_sat_r;

endmodule

// ===== dv/tb_biquad_cascade_sum_squares.sv =====
`timescale 1ns / 1ps

module tb_biquad_cascade_sum_squares;
  import bqss_pkg::*;

  // Sizes of the cascade as instantiated (package defaults).
  localparam int MAX_SEC = MAX_SECTIONS_DEF;
  localparam int ST_W    = STATE_WIDTH_DEF;

  // The drain wait covers the longest sample inside the block, with margin,
  // before a register write or the final verdict.
  localparam int DRAIN_CYCLES = 8 * MAX_SEC + 16;

  // Cycles without any transfer on any channel before the run is declared
  // hung.
  localparam int QUIET_LIMIT = 4000;

  // Register index that maps to no register; writes to it must be ignored.
  localparam logic [1:0] CFG_SPARE_IDX = 2'd3;

  // Fixed-point limits and rounding offsets used by the predictor.
  localparam logic signed [127:0] ROUND_Q28 = 128'sd1 <<< (FRAC_C - 1);
  localparam logic signed [127:0] ROUND_Q44 = 128'sd1 <<< 43;
  localparam logic signed [127:0] STATE_MAX = (128'sd1 <<< (ST_W - 1)) - 128'sd1;
  localparam logic signed [127:0] STATE_MIN = -(128'sd1 <<< (ST_W - 1));
  localparam logic signed [127:0] OUT_MAX   = (128'sd1 <<< 31) - 128'sd1;
  localparam logic signed [127:0] OUT_MIN   = -(128'sd1 <<< 31);

  // One result transfer as the predictor expects it.
  typedef struct packed {
    logic signed [31:0] filtered;
    logic [63:0]        sum_sq;
    logic               last;
    logic               clipped;
  } filt_result_t;

  logic clk;
  logic rst_n;

  logic                        in_valid;
  logic                        in_stall;
  logic                        in_command;
  logic signed [23:0]          in_sample;
  logic                        in_last_in;
  logic [1:0]                  in_section_index;
  logic [1:0]                  in_coef_select;
  logic signed [31:0]          in_coef_value;

  logic                        out_valid;
  logic                        out_stall;
  logic signed [31:0]          out_filtered_sample;
  logic [63:0]                 out_block_sum_squares;
  logic                        out_last_out;
  logic                        out_saturated;

  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index;
  logic [31:0]                 cfg_data;

  biquad_cascade_sum_squares u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_command            (in_command),
    .in_sample             (in_sample),
    .in_last_in            (in_last_in),
    .in_section_index      (in_section_index),
    .in_coef_select        (in_coef_select),
    .in_coef_value         (in_coef_value),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_filtered_sample   (out_filtered_sample),
    .out_block_sum_squares (out_block_sum_squares),
    .out_last_out          (out_last_out),
    .out_saturated         (out_saturated),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  // Predictor copy of the block's state and registers. It is updated at the
  // moment each transfer is accepted, in the order the block sees them.
  logic signed [31:0]     coef_mem [MAX_SEC][4];
  logic signed [ST_W-1:0] dly_w0 [MAX_SEC];
  logic signed [ST_W-1:0] dly_w1 [MAX_SEC];
  logic [63:0]            sum_sq_acc;
  logic signed [31:0]     gain_q28;
  logic [2:0]             sections_cfg;
  logic                   clip_seen;

  // Outputs still owed by the block, oldest first.
  filt_result_t pending_outputs [$];
  filt_result_t oldest;

  // Idling controls: in_gap_max bounds the sender's random gap before each
  // item, stall_max the receiver's random stall after each result transfer.
  int in_gap_max;
  int stall_max;
  int stall_left;
  int quiet_cycles;

  // Run statistics and the failure count.
  int mismatches;
  int samples_sent;
  int coef_writes;
  int reg_writes;
  int blocks_closed;
  int clipped_results;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Round a Q28-scaled sum back to the delay-line format and clip it to the
  // state width. Any clip is remembered for the sample being processed.
  function automatic logic signed [ST_W-1:0] to_state(input logic signed [127:0] acc);
    logic signed [127:0] r;
    r = (acc + ROUND_Q28) >>> FRAC_C;
    if (r > STATE_MAX) begin
      clip_seen = 1'b1;
      r = STATE_MAX;
    end else if (r < STATE_MIN) begin
      clip_seen = 1'b1;
      r = STATE_MIN;
    end
    return r[ST_W-1:0];
  endfunction

  // Run one sample through the predictor's cascade and queue the result the
  // block must produce for it.
  task automatic predict_sample(input logic signed [23:0] smp, input logic last);
    int n;
    int s;
    logic signed [127:0] x;
    logic signed [127:0] acc;
    logic signed [127:0] w0;
    logic signed [127:0] w1;
    logic signed [127:0] wn;
    logic signed [127:0] b1;
    logic signed [127:0] b2;
    logic signed [127:0] a1;
    logic signed [127:0] a2;
    logic signed [127:0] g;
    logic signed [ST_W-1:0] w_next;
    logic signed [ST_W-1:0] y_next;
    logic [31:0] mag;
    logic [63:0] sq;
    logic [64:0] total;
    filt_result_t r;
    clip_seen = 1'b0;
    n = sections_cfg;
    if (n < 1) n = 1;
    if (n > MAX_SEC) n = MAX_SEC;
    x = smp;
    x = x <<< 16;
    for (s = 0; s < n; s++) begin
      w0 = dly_w0[s];
      w1 = dly_w1[s];
      b1 = coef_mem[s][COEF_B1];
      b2 = coef_mem[s][COEF_B2];
      a1 = coef_mem[s][COEF_A1];
      a2 = coef_mem[s][COEF_A2];
      acc = (x <<< FRAC_C) + w0 * a1 + w1 * a2;
      w_next = to_state(acc);
      wn = w_next;
      acc = (wn <<< FRAC_C) + w0 * b1 + w1 * b2;
      y_next = to_state(acc);
      dly_w1[s] = dly_w0[s];
      dly_w0[s] = w_next;
      x = y_next;
    end
    g = gain_q28;
    acc = (x * g + ROUND_Q44) >>> 44;
    if (acc > OUT_MAX) begin
      clip_seen = 1'b1;
      acc = OUT_MAX;
    end else if (acc < OUT_MIN) begin
      clip_seen = 1'b1;
      acc = OUT_MIN;
    end
    r.filtered = acc[31:0];
    mag = r.filtered[31] ? (~r.filtered + 32'd1) : r.filtered;
    sq = 64'(mag) * 64'(mag);
    total = {1'b0, sum_sq_acc} + {1'b0, sq};
    if (total[64]) begin
      clip_seen = 1'b1;
      sum_sq_acc = '1;
    end else begin
      sum_sq_acc = total[63:0];
    end
    r.last = last;
    if (last) begin
      r.sum_sq = sum_sq_acc;
      sum_sq_acc = '0;
      blocks_closed++;
    end else begin
      r.sum_sq = '0;
    end
    r.clipped = clip_seen;
    if (clip_seen) clipped_results++;
    samples_sent++;
    pending_outputs.push_back(r);
  endtask

  // Present one item on the input channel after a random gap and hold it
  // until the block takes it. Valid is left high after the transfer; the
  // next call or a drain replaces or lowers it at the following falling edge.
  task automatic send_item(input logic cmd, input logic signed [23:0] smp,
                           input logic last, input logic [1:0] sec,
                           input logic [1:0] sel, input logic signed [31:0] val);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_sample        <= smp;
    in_last_in       <= last;
    in_section_index <= sec;
    in_coef_select   <= sel;
    in_coef_value    <= val;
    do @(posedge clk); while (in_stall);
    if (cmd == CMD_COEF) begin
      // The last flag means nothing on a coefficient write.
      coef_mem[sec][sel] = val;
      coef_writes++;
    end else begin
      predict_sample(smp, last);
    end
  endtask

  // A filter item; the coefficient fields carry random noise.
  task automatic send_sample(input logic signed [23:0] smp, input logic last);
    send_item(CMD_FILTER, smp, last, 2'($urandom()), 2'($urandom()), $urandom());
  endtask

  // A coefficient item; the sample field carries random noise.
  task automatic send_coef(input logic [1:0] sec, input logic [1:0] sel,
                           input logic signed [31:0] val, input logic last);
    send_item(CMD_COEF, 24'($urandom()), last, sec, sel, val);
  endtask

  // Stop sending and wait until the block has delivered every owed result,
  // then wait out the DRAIN_CYCLES margin before going on.
  task automatic drain_pipeline();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; only called while the block is idle.
  task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_OUTPUT_GAIN:   gain_q28 = data;
      CFG_SECTIONS_USED: sections_cfg = data[2:0];
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Coefficient values: feedback terms stay within +-0.5 so the sections
  // remain stable, feedforward terms within +-2.0. Wild values use the whole
  // 32-bit range and tend to drive the state into clipping.
  function automatic logic signed [31:0] pick_coef(input logic [1:0] sel, input bit wild);
    if (wild) return $urandom();
    if (sel == COEF_A1 || sel == COEF_A2)
      return int'($urandom_range(0, 32'h1000_0000)) - 32'h0800_0000;
    return int'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
  endfunction

  // With all coefficients at reset (zero), one section and unity gain, each
  // output equals its input sample. Covers the sample extremes, a block sum
  // over full-scale squares, and a last flag on a coefficient write, which
  // must leave the running sum alone.
  task automatic test_passthrough();
    send_sample(24'sh000000, 1'b0);
    send_sample(24'sh7FFFFF, 1'b0);
    send_sample(-24'sh800000, 1'b1);
    send_sample(-24'sh000001, 1'b0);
    send_coef(2'd1, COEF_B1, 32'sh0000_0000, 1'b1);
    send_sample(24'sh000001, 1'b1);
    send_sample(24'sh000005, 1'b1);
  endtask

  // Writes section 0's four coefficient slots with extreme values, and a1 of
  // the last section's index. The resulting unstable section clips the delay
  // line, the output and, after several full-scale squares, the block sum.
  task automatic test_coefficient_extremes();
    int k;
    drain_pipeline();
    write_register(CFG_OUTPUT_GAIN, 32'h7FFF_FFFF);
    send_coef(2'd0, COEF_B1, 32'sh7FFF_FFFF, 1'b0);
    send_coef(2'd0, COEF_B2, 32'sh8000_0000, 1'b0);
    send_coef(2'd0, COEF_A1, 32'sh7FFF_FFFF, 1'b0);
    send_coef(2'd0, COEF_A2, 32'sh8000_0000, 1'b0);
    send_coef(2'd3, COEF_A1, 32'sh8000_0000, 1'b1);
    for (k = 0; k < 7; k++) send_sample(24'sh7FFFFF, k == 6);
  endtask

  // Section counts outside the working range: zero acts as one section,
  // anything above the cascade length uses every section. Also the most
  // negative and the zero gain, and a write to an index that has no register.
  task automatic test_register_limits();
    drain_pipeline();
    write_register(CFG_OUTPUT_GAIN, 32'h8000_0000);
    write_register(CFG_SECTIONS_USED, 32'd0);
    write_register(CFG_SPARE_IDX, $urandom());
    send_sample(24'sh123456, 1'b0);
    drain_pipeline();
    write_register(CFG_SECTIONS_USED, 32'd5);
    send_sample(-24'sh400000, 1'b0);
    drain_pipeline();
    write_register(CFG_SECTIONS_USED, 32'd7);
    send_sample(24'sh7FFFFF, 1'b1);
    drain_pipeline();
    write_register(CFG_OUTPUT_GAIN, 32'h0000_0000);
    send_sample(-24'sh800000, 1'b1);
  endtask

  // Phases of random traffic. Each phase sets both registers, loads a fresh
  // set of coefficients and then streams samples in blocks of random length
  // with a sprinkling of coefficient rewrites. One phase runs with no idling
  // at all, one with a sender that never idles against a stalling receiver,
  // and one pauses the sender halfway until every result has come back.
  task automatic test_random_traffic();
    logic [2:0] sect_plan [8];
    int p;
    int k;
    int s;
    int c;
    logic [31:0] g;
    logic signed [23:0] smp;
    sect_plan = '{3'd1, 3'd4, 3'd2, 3'd7, 3'd3, 3'd0, 3'd4, 3'd6};
    for (p = 0; p < 8; p++) begin
      drain_pipeline();
      case (p)
        2: begin
          in_gap_max = 0;
          stall_max  = 0;
        end
        5: begin
          in_gap_max = 0;
          stall_max  = 11;
        end
        default: begin
          in_gap_max = 11;
          stall_max  = 11;
        end
      endcase
      case (p)
        0: g = GAIN_RESET;
        1: g = 32'h7FFF_FFFF;
        3: g = 32'h8000_0000;
        default: begin
          if ($urandom_range(0, 3) == 0) g = $urandom();
          else g = int'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
        end
      endcase
      write_register(CFG_OUTPUT_GAIN, g);
      write_register(CFG_SECTIONS_USED, {29'd0, sect_plan[p]});
      for (s = 0; s < MAX_SEC; s++) begin
        for (c = 0; c < 4; c++) begin
          send_coef(2'(s), 2'(c), pick_coef(2'(c), $urandom_range(0, 15) == 0),
                    1'($urandom()));
        end
      end
      for (k = 0; k < 95; k++) begin
        if (p == 4 && k == 47) drain_pipeline();
        if ($urandom_range(0, 9) == 0) begin
          c = $urandom_range(0, 3);
          send_coef(2'($urandom()), 2'(c), pick_coef(2'(c), $urandom_range(0, 3) == 0),
                    1'($urandom()));
        end else begin
          case ($urandom_range(0, 9))
            0: smp = 24'sh7FFFFF;
            1: smp = -24'sh800000;
            2: smp = 24'sh000000;
            3: smp = -24'sh000001;
            default: smp = 24'($urandom());
          endcase
          send_sample(smp, $urandom_range(0, 5) == 0);
        end
      end
    end
  endtask

  // Receiver stall: after each result transfer a fresh stall length is drawn,
  // and the stall is driven from the falling edge while it counts down.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker: each accepted result is compared with the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      stall_left = $urandom_range(0, stall_max);
      if (pending_outputs.size() == 0) begin
        $error("result transfer with no sample outstanding: filtered_sample %0d",
               out_filtered_sample);
        mismatches++;
      end else begin
        oldest = pending_outputs.pop_front();
        if (out_filtered_sample !== oldest.filtered) begin
          $error("filtered_sample: expected %0d, actual %0d",
                 oldest.filtered, out_filtered_sample);
          mismatches++;
        end
        if (out_block_sum_squares !== oldest.sum_sq) begin
          $error("block_sum_squares: expected %0d, actual %0d",
                 oldest.sum_sq, out_block_sum_squares);
          mismatches++;
        end
        if (out_last_out !== oldest.last) begin
          $error("last_out: expected %0b, actual %0b", oldest.last, out_last_out);
          mismatches++;
        end
        if (out_saturated !== oldest.clipped) begin
          $error("saturated: expected %0b, actual %0b", oldest.clipped, out_saturated);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: any transfer on any channel restarts the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d results outstanding.",
               QUIET_LIMIT, pending_outputs.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int s;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_command       = CMD_FILTER;
    in_sample        = '0;
    in_last_in       = 1'b0;
    in_section_index = '0;
    in_coef_select   = COEF_B1;
    in_coef_value    = '0;
    out_stall        = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = CFG_OUTPUT_GAIN;
    cfg_data         = '0;
    in_gap_max       = 11;
    stall_max        = 11;
    stall_left       = 0;
    quiet_cycles     = 0;
    mismatches       = 0;
    samples_sent     = 0;
    coef_writes      = 0;
    reg_writes       = 0;
    blocks_closed    = 0;
    clipped_results  = 0;

    // Predictor starts from the reset state of the block.
    for (s = 0; s < MAX_SEC; s++) begin
      coef_mem[s] = '{default: '0};
      dly_w0[s] = '0;
      dly_w1[s] = '0;
    end
    sum_sq_acc   = '0;
    gain_q28     = GAIN_RESET;
    sections_cfg = 3'd1;

    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_passthrough();
    test_coefficient_extremes();
    test_register_limits();
    test_random_traffic();

    // Let the last results drain, then leave room for anything stray.
    drain_pipeline();

    $display("Run covered %0d filtered samples, %0d coefficient writes, %0d register writes.",
             samples_sent, coef_writes, reg_writes);
    $display("It closed %0d blocks and saw %0d samples with clipping in the chain.",
             blocks_closed, clipped_results);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
